// File: rtl/core/irpc_pkg.sv
package irpc_pkg;

   // Widths of the register fields and of the result count
   localparam int TIMEOUT_W    = 12;
   localparam int LIMIT_W      = 9;
   localparam int PAIR_COUNT_W = 9;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 12'd2000;
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 9'd200;

   // Register index, taken from paddr[2]
   localparam logic REG_TIMEOUT = 1'b0;
   localparam logic REG_LIMIT   = 1'b1;

   // Event codes
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_DONE  = 2'd1;
   localparam logic [1:0] EV_ERROR = 2'd2;

   typedef struct packed {
      logic rx_level;
      logic replay_request;
   } req_word_type;

   typedef struct packed {
      logic                    tx_level;
      logic                    busy_res;
      logic [1:0]              event_code;
      logic [PAIR_COUNT_W-1:0] pair_count;
   } rsp_word_type;

endpackage

// File: rtl/core/irpc_pair_mem.sv
module irpc_pair_mem #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // write-first: a same-address write shows up on the read port at once
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/irpc_seq.sv
module irpc_seq #(
   parameter int MAX_PAIRS  = 256,
   parameter int COUNT_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  irpc_pkg::req_word_type              req_word,
   input  logic [irpc_pkg::TIMEOUT_W-1:0]      pulse_timeout,
   input  logic [irpc_pkg::LIMIT_W-1:0]        pair_limit,
   input  logic [2*COUNT_BITS-1:0]             rd_data,
   output logic [$clog2(MAX_PAIRS)-1:0]        rd_addr,
   output logic                                wr_en,
   output logic [$clog2(MAX_PAIRS)-1:0]        wr_addr,
   output logic [2*COUNT_BITS-1:0]             wr_data,
   output irpc_pkg::rsp_word_type              rsp_word
);

   localparam int IW   = $clog2(MAX_PAIRS);
   localparam int PCW  = $clog2(MAX_PAIRS + 1);
   localparam int CB   = COUNT_BITS;
   localparam int TCW  = (CB > irpc_pkg::TIMEOUT_W) ? CB : irpc_pkg::TIMEOUT_W;
   localparam int LCW  = (PCW > irpc_pkg::LIMIT_W) ? PCW : irpc_pkg::LIMIT_W;
   localparam logic [TCW-1:0] CntMax  = TCW'((1 << CB) - 1);
   localparam logic [LCW-1:0] PairMax = LCW'(MAX_PAIRS);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_CAP_ON,
      MODE_CAP_OFF,
      MODE_REP_ON,
      MODE_REP_OFF
   } mode_type;

   mode_type       mode_ff, mode_in;
   logic [PCW-1:0] pi_ff, pi_in;
   logic [CB-1:0]  wc_ff, wc_in;
   logic [PCW-1:0] cnt_ff, cnt_in;
   logic [CB-1:0]  on_ff, on_in;

   logic [TCW-1:0] tmo_ext;
   logic [CB-1:0]  tmo;
   logic           tmo_one;
   logic [LCW-1:0] lim_ext;
   logic [PCW-1:0] lim;

   logic [CB-1:0]  wc_inc;
   logic [PCW-1:0] pi_inc;

   logic           rep_on;
   logic [PCW-1:0] rep_pi;
   logic [CB-1:0]  rep_wc_inc;
   logic [CB-1:0]  rep_w;
   logic           rep_done;
   logic [PCW-1:0] rep_pi_inc;

   logic           tx;
   logic           busy;
   logic [1:0]     ev;

   // effective timeout: zero acts as one, saturates at the counter range
   always_comb begin
      tmo_ext = TCW'(pulse_timeout);
      if (tmo_ext == '0) begin
         tmo_ext = TCW'(1);
      end else if (tmo_ext > CntMax) begin
         tmo_ext = CntMax;
      end
      tmo     = tmo_ext[CB-1:0];
      tmo_one = (tmo == CB'(1));
   end

   always_comb begin
      lim_ext = LCW'(pair_limit);
      if (lim_ext == '0) begin
         lim_ext = LCW'(1);
      end else if (lim_ext > PairMax) begin
         lim_ext = PairMax;
      end
      lim = lim_ext[PCW-1:0];
   end

   assign wc_inc = wc_ff + 1'b1;
   assign pi_inc = pi_ff + 1'b1;

   // playback step; starting from idle it runs on pair 0 with a zero count
   always_comb begin
      rep_on     = (mode_ff != MODE_REP_OFF);
      rep_pi     = (mode_ff == MODE_IDLE) ? '0 : pi_ff;
      rep_wc_inc = ((mode_ff == MODE_IDLE) ? '0 : wc_ff) + 1'b1;
      rep_w      = rep_on ? rd_data[2*CB-1:CB] : rd_data[CB-1:0];
      rep_done   = (rep_wc_inc >= rep_w) || (rep_wc_inc == '0);
      rep_pi_inc = rep_pi + 1'b1;
   end

   always_comb begin
      mode_in = mode_ff;
      pi_in   = pi_ff;
      wc_in   = wc_ff;
      cnt_in  = cnt_ff;
      on_in   = on_ff;
      wr_en   = 1'b0;
      wr_data = {on_ff, wc_ff};
      tx      = 1'b0;
      busy    = 1'b0;
      ev      = irpc_pkg::EV_NONE;
      if (fire) begin
         unique case (mode_ff)
            MODE_IDLE: begin
               if (req_word.replay_request && (cnt_ff != '0)) begin
                  mode_in = MODE_REP_ON;
               end else if (req_word.rx_level) begin
                  busy   = 1'b1;
                  cnt_in = '0;
                  pi_in  = '0;
                  wc_in  = CB'(1);
                  if (tmo_one) begin
                     mode_in = MODE_IDLE;
                     ev      = irpc_pkg::EV_ERROR;
                  end else begin
                     mode_in = MODE_CAP_ON;
                  end
               end
            end
            MODE_CAP_ON: begin
               busy = 1'b1;
               if (req_word.rx_level) begin
                  wc_in = wc_inc;
                  if (wc_inc >= tmo) begin
                     mode_in = MODE_IDLE;
                     cnt_in  = '0;
                     ev      = irpc_pkg::EV_ERROR;
                  end
               end else begin
                  on_in   = wc_ff;
                  wc_in   = CB'(1);
                  mode_in = MODE_CAP_OFF;
                  if (tmo_one) begin
                     wr_en   = 1'b1;
                     wr_data = {wc_ff, CB'(1)};
                     mode_in = MODE_IDLE;
                     cnt_in  = pi_inc;
                     ev      = irpc_pkg::EV_DONE;
                  end
               end
            end
            MODE_CAP_OFF: begin
               busy = 1'b1;
               if (!req_word.rx_level) begin
                  wc_in = wc_inc;
                  if (wc_inc >= tmo) begin
                     wr_en   = 1'b1;
                     wr_data = {on_ff, wc_inc};
                     mode_in = MODE_IDLE;
                     cnt_in  = pi_inc;
                     ev      = irpc_pkg::EV_DONE;
                  end
               end else begin
                  wr_en = 1'b1;
                  pi_in = pi_inc;
                  if (pi_inc >= lim) begin
                     mode_in = MODE_IDLE;
                     cnt_in  = pi_inc;
                     ev      = irpc_pkg::EV_DONE;
                  end else begin
                     wc_in   = CB'(1);
                     mode_in = MODE_CAP_ON;
                     if (tmo_one) begin
                        mode_in = MODE_IDLE;
                        cnt_in  = '0;
                        ev      = irpc_pkg::EV_ERROR;
                     end
                  end
               end
            end
            MODE_REP_ON, MODE_REP_OFF: begin
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase

         if (mode_in == MODE_REP_ON || mode_in == MODE_REP_OFF) begin
            busy  = 1'b1;
            tx    = rep_on;
            pi_in = rep_pi;
            if (rep_done) begin
               wc_in = '0;
               if (rep_on) begin
                  mode_in = MODE_REP_OFF;
               end else begin
                  pi_in   = rep_pi_inc;
                  mode_in = (rep_pi_inc >= cnt_ff) ? MODE_IDLE : MODE_REP_ON;
               end
            end else begin
               wc_in = rep_wc_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pi_ff   <= '0;
         wc_ff   <= '0;
         cnt_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         pi_ff   <= pi_in;
         wc_ff   <= wc_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      on_ff <= on_in;
   end

   // prefetch the pair the next word will need; idle points at pair 0
   assign rd_addr = (mode_in == MODE_REP_ON || mode_in == MODE_REP_OFF) ?
                    pi_in[IW-1:0] : '0;
   assign wr_addr = pi_ff[IW-1:0];

   assign rsp_word.tx_level   = tx;
   assign rsp_word.busy_res   = busy;
   assign rsp_word.event_code = ev;
   assign rsp_word.pair_count = irpc_pkg::PAIR_COUNT_W'(cnt_in);

   a_err_clears_count: assert property (@(posedge clock) disable iff (reset)
      (fire && ev == irpc_pkg::EV_ERROR) |-> (cnt_in == '0))
      else $error("capture error left a nonzero pair count");

   a_capture_count_zero: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_CAP_ON || mode_ff == MODE_CAP_OFF) |-> (cnt_ff == '0))
      else $error("stored count nonzero during capture");

   a_replay_in_range: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_REP_ON || mode_ff == MODE_REP_OFF) |-> (pi_ff < cnt_ff))
      else $error("playback index beyond stored count");

   a_write_in_capture: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (fire && (mode_ff == MODE_CAP_ON || mode_ff == MODE_CAP_OFF)))
      else $error("pair memory written outside capture");

   a_hold_without_word: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(mode_ff) && $stable(pi_ff) && $stable(cnt_ff)))
      else $error("sequencer state moved without an accepted word");

endmodule

// File: rtl/core/ir_pulse_capture_replay.sv
// channel | direction | handshake            | word
// req     | in        | req_valid / req_stall | irpc_pkg::req_word_type (one tick)
// rsp     | out       | rsp_valid / rsp_stall | irpc_pkg::rsp_word_type (one per tick)
// csr     | in/out    | psel/penable/pready   | pulse_timeout @0x0, pair_limit @0x4
//
// One word per clock unless a held result is stalled; a tick is processed in
// the cycle it is accepted and its result lands in the output register on the
// same edge. The pair memory read port is prefetched from the next sequencer
// state, so playback of a new pair never waits on the read.
// Reset clears the sequencer and registers, not the pair memory (no clearing pass).
// req_stall is high only while a held result sees rsp_stall high.
module ir_pulse_capture_replay #(
   parameter int MAX_PAIRS  = 256,
   parameter int COUNT_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  irpc_pkg::req_word_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output irpc_pkg::rsp_word_type              rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [irpc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [irpc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [irpc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int IW = $clog2(MAX_PAIRS);

   logic [irpc_pkg::TIMEOUT_W-1:0] timeout_ff;
   logic [irpc_pkg::LIMIT_W-1:0]   limit_ff;
   logic                           csr_wr;
   logic                           reg_sel;

   logic                           fire;
   logic                           rsp_valid_ff, rsp_valid_in;
   irpc_pkg::rsp_word_type         rsp_data_ff;
   irpc_pkg::rsp_word_type         seq_word;

   logic [IW-1:0]                  rd_addr;
   logic [IW-1:0]                  wr_addr;
   logic                           wr_en;
   logic [2*COUNT_BITS-1:0]        wr_data;
   logic [2*COUNT_BITS-1:0]        rd_data;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign reg_sel = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= irpc_pkg::TIMEOUT_RESET;
         limit_ff   <= irpc_pkg::LIMIT_RESET;
      end else if (csr_wr) begin
         unique case (reg_sel)
            irpc_pkg::REG_TIMEOUT: timeout_ff <= pwdata[irpc_pkg::TIMEOUT_W-1:0];
            irpc_pkg::REG_LIMIT:   limit_ff   <= pwdata[irpc_pkg::LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         irpc_pkg::REG_TIMEOUT: prdata = irpc_pkg::CSR_DATA_W'(timeout_ff);
         irpc_pkg::REG_LIMIT:   prdata = irpc_pkg::CSR_DATA_W'(limit_ff);
         default:               prdata = '0;
      endcase
   end

   // output register: take a new word whenever the held one is empty or leaving
   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign fire         = req_valid && !req_stall;
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= seq_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   irpc_seq #(
      .MAX_PAIRS  (MAX_PAIRS),
      .COUNT_BITS (COUNT_BITS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .req_word      (req_data),
      .pulse_timeout (timeout_ff),
      .pair_limit    (limit_ff),
      .rd_data       (rd_data),
      .rd_addr       (rd_addr),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rsp_word      (seq_word)
   );

   irpc_pair_mem #(
      .DEPTH (MAX_PAIRS),
      .WIDTH (2*COUNT_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// File: sim/tb_ir_pulse_capture_replay.sv
module tb_ir_pulse_capture_replay;

   localparam int PAIR_SLOTS  = 256;
   localparam int WIDTH_BITS  = 12;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;

   typedef enum logic [2:0] {
      SEQ_IDLE, SEQ_CAP_ON, SEQ_CAP_OFF, SEQ_PLAY_ON, SEQ_PLAY_OFF
   } seq_mode_type;

   // Tracks the capture/replay sequencer and holds the words it should produce
   class pulse_replay_scoreboard;
      logic [irpc_pkg::TIMEOUT_W-1:0]    timeout_reg;
      logic [irpc_pkg::LIMIT_W-1:0]      limit_reg;
      seq_mode_type                      seq_mode;
      logic [WIDTH_BITS-1:0]             on_width[PAIR_SLOTS];
      logic [WIDTH_BITS-1:0]             off_width[PAIR_SLOTS];
      int unsigned                       pair_idx;
      logic [WIDTH_BITS-1:0]             width_cnt;
      logic [irpc_pkg::PAIR_COUNT_W-1:0] stored;
      irpc_pkg::rsp_word_type            expected_words[$];
      int errors, results_seen, captures_done, captures_failed, replays, most_pairs;

      function new();
         timeout_reg = irpc_pkg::TIMEOUT_RESET;
         limit_reg   = irpc_pkg::LIMIT_RESET;
         seq_mode    = SEQ_IDLE;
         pair_idx    = 0;
         width_cnt   = '0;
         stored      = '0;
         foreach (on_width[i]) begin
            on_width[i]  = '0;
            off_width[i] = '0;
         end
         errors = 0; results_seen = 0; captures_done = 0;
         captures_failed = 0; replays = 0; most_pairs = 0;
      endfunction

      function void write_reg(logic sel, logic [irpc_pkg::CSR_DATA_W-1:0] value);
         if (sel == irpc_pkg::REG_TIMEOUT) timeout_reg = value[irpc_pkg::TIMEOUT_W-1:0];
         else limit_reg = value[irpc_pkg::LIMIT_W-1:0];
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) $display("MISMATCH: %s", msg);
      endfunction

      function void note_tick(irpc_pkg::req_word_type w);
         irpc_pkg::rsp_word_type r;
         int unsigned  tmo, lim, slot, span;
         logic         tx, busy;
         logic [1:0]   ev;
         tmo  = (timeout_reg == 0) ? 1 : timeout_reg;
         lim  = (limit_reg == 0) ? 1 : ((limit_reg > PAIR_SLOTS) ? PAIR_SLOTS : limit_reg);
         slot = (pair_idx >= PAIR_SLOTS) ? PAIR_SLOTS - 1 : pair_idx;
         tx   = 1'b0;
         busy = 1'b0;
         ev   = irpc_pkg::EV_NONE;
         case (seq_mode)
            SEQ_CAP_ON: begin
               busy = 1'b1;
               if (w.rx_level) begin
                  width_cnt = width_cnt + 1'b1;
                  if (width_cnt >= tmo) begin
                     on_width[slot] = width_cnt;
                     seq_mode = SEQ_IDLE;
                     stored = '0;
                     ev = irpc_pkg::EV_ERROR;
                  end
               end else begin
                  on_width[slot] = width_cnt;
                  width_cnt = WIDTH_BITS'(1);
                  if (width_cnt >= tmo) begin
                     off_width[slot] = width_cnt;
                     seq_mode = SEQ_IDLE;
                     stored = irpc_pkg::PAIR_COUNT_W'(pair_idx + 1);
                     ev = irpc_pkg::EV_DONE;
                  end else seq_mode = SEQ_CAP_OFF;
               end
            end
            SEQ_CAP_OFF: begin
               busy = 1'b1;
               if (!w.rx_level) begin
                  width_cnt = width_cnt + 1'b1;
                  if (width_cnt >= tmo) begin
                     off_width[slot] = width_cnt;
                     seq_mode = SEQ_IDLE;
                     stored = irpc_pkg::PAIR_COUNT_W'(pair_idx + 1);
                     ev = irpc_pkg::EV_DONE;
                  end
               end else begin
                  off_width[slot] = width_cnt;
                  pair_idx++;
                  if (pair_idx >= lim) begin
                     seq_mode = SEQ_IDLE;
                     stored = irpc_pkg::PAIR_COUNT_W'(pair_idx);
                     ev = irpc_pkg::EV_DONE;
                  end else begin
                     width_cnt = WIDTH_BITS'(1);
                     if (width_cnt >= tmo) begin
                        seq_mode = SEQ_IDLE;
                        stored = '0;
                        ev = irpc_pkg::EV_ERROR;
                     end else seq_mode = SEQ_CAP_ON;
                  end
               end
            end
            SEQ_PLAY_ON, SEQ_PLAY_OFF: ;
            default: begin
               seq_mode = SEQ_IDLE;
               if (w.replay_request && stored != 0) begin
                  seq_mode  = SEQ_PLAY_ON;
                  pair_idx  = 0;
                  width_cnt = '0;
                  replays++;
               end else if (w.rx_level) begin
                  // this tick already counts as the first on tick
                  busy      = 1'b1;
                  stored    = '0;
                  pair_idx  = 0;
                  width_cnt = WIDTH_BITS'(1);
                  if (width_cnt >= tmo) ev = irpc_pkg::EV_ERROR;
                  else seq_mode = SEQ_CAP_ON;
               end
            end
         endcase

         if (seq_mode == SEQ_PLAY_ON || seq_mode == SEQ_PLAY_OFF) begin
            busy = 1'b1;
            slot = (pair_idx >= PAIR_SLOTS) ? PAIR_SLOTS - 1 : pair_idx;
            tx   = (seq_mode == SEQ_PLAY_ON);
            span = 32'(tx ? on_width[slot] : off_width[slot]);
            width_cnt = width_cnt + 1'b1;
            if (width_cnt >= span || width_cnt == 0) begin
               width_cnt = '0;
               if (seq_mode == SEQ_PLAY_ON) seq_mode = SEQ_PLAY_OFF;
               else begin
                  pair_idx++;
                  seq_mode = (pair_idx >= stored) ? SEQ_IDLE : SEQ_PLAY_ON;
               end
            end
         end

         if (ev == irpc_pkg::EV_DONE) captures_done++;
         if (ev == irpc_pkg::EV_ERROR) captures_failed++;
         if (stored > most_pairs) most_pairs = int'(stored);
         r.tx_level   = tx;
         r.busy_res   = busy;
         r.event_code = ev;
         r.pair_count = stored;
         expected_words.push_back(r);
      endfunction

      function void check_result(irpc_pkg::rsp_word_type got);
         irpc_pkg::rsp_word_type want;
         results_seen++;
         if (expected_words.size() == 0) begin
            report($sformatf("result word %0d arrived with none expected: %p",
                             results_seen, got));
            return;
         end
         want = expected_words.pop_front();
         if (got !== want)
            report($sformatf({"word %0d: expected tx %b busy %b event %0d count %0d, ",
                              "got tx %b busy %b event %0d count %0d"}, results_seen,
                             want.tx_level, want.busy_res, want.event_code, want.pair_count,
                             got.tx_level, got.busy_res, got.event_code, got.pair_count));
      endfunction

      function void close();
         if (expected_words.size() != 0)
            report($sformatf("%0d expected words never came out", expected_words.size()));
      endfunction
   endclass

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   irpc_pkg::req_word_type          req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   irpc_pkg::rsp_word_type          rsp_data;
   logic                            psel      = 1'b0;
   logic                            penable   = 1'b0;
   logic                            pwrite    = 1'b0;
   logic [irpc_pkg::CSR_ADDR_W-1:0] paddr     = '0;
   logic [irpc_pkg::CSR_DATA_W-1:0] pwdata    = '0;
   logic [irpc_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   pulse_replay_scoreboard sb;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int hold_asks     = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int ticks_sent    = 0;
   int cycle_count   = 0;
   int idle_pct[4]   = '{0, 87, 0, 20};
   int stall_pct[4]  = '{0, 0, 87, 20};
   // {rx_level, replay_request}
   logic [1:0] directed_ticks[22] = '{
      2'b01, 2'b10, 2'b11, 2'b10, 2'b10, 2'b00, 2'b10, 2'b01, 2'b00, 2'b00, 2'b11,
      2'b00, 2'b10, 2'b00, 2'b01, 2'b00, 2'b10, 2'b00, 2'b10, 2'b00, 2'b11, 2'b01};

   ir_pulse_capture_replay #(.MAX_PAIRS(PAIR_SLOTS), .COUNT_BITS(WIDTH_BITS)) i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped at cycle limit %0d", CYCLE_LIMIT);
         $display("tb_ir_pulse_capture_replay: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // receiver: random stalls plus one long hold-off in the first random phase
   always @(negedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   task automatic send_word(input logic rx, input logic rq);
      irpc_pkg::req_word_type w;
      w.rx_level       = rx;
      w.replay_request = rq;
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      sb.note_tick(w);
      ticks_sent++;
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // run the sequencer back to idle: low level ends a capture, replay runs out
   task automatic settle();
      while (sb.seq_mode != SEQ_IDLE) begin
         if (sb.seq_mode == SEQ_CAP_ON || sb.seq_mode == SEQ_CAP_OFF)
            send_word(1'b0, 1'($urandom_range(1)));
         else
            send_word(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
   endtask

   task automatic capture_train(input int pairs, input int max_w);
      int w_on, w_off;
      settle();
      for (int p = 0; p < pairs; p++) begin
         w_on  = $urandom_range(1, max_w);
         w_off = $urandom_range(1, max_w);
         for (int k = 0; k < w_on; k++) begin
            send_word(1'b1, (p == 0 && k == 0) ? 1'b0 : 1'($urandom_range(1)));
            if (sb.seq_mode == SEQ_IDLE) return;
         end
         for (int k = 0; k < w_off; k++) begin
            send_word(1'b0, 1'($urandom_range(1)));
            if (sb.seq_mode == SEQ_IDLE) return;
         end
      end
      settle();
   endtask

   task automatic replay_run();
      settle();
      send_word(1'($urandom_range(1)), 1'b1);
      settle();
   endtask

   task automatic noise(input int n);
      for (int i = 0; i < n; i++) send_word(1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic csr_write(input logic sel, input logic [irpc_pkg::CSR_DATA_W-1:0] value);
      logic [irpc_pkg::CSR_DATA_W-1:0] mask;
      mask = (sel == irpc_pkg::REG_TIMEOUT) ? (1 << irpc_pkg::TIMEOUT_W) - 1 :
                                              (1 << irpc_pkg::LIMIT_W) - 1;
      settle();
      wait_quiet();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_reg(sel, value);
      // read back with psel held
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if ((prdata & mask) !== (value & mask))
         sb.report($sformatf("register at 0x%0h reads 0x%0h, written 0x%0h",
                             {sel, 2'b00}, prdata, value));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      int phase_start, tmo_cur, lim_cur, pick;
      sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // short hand-built train: on timeout, off timeout, replay, pair limit
      csr_write(irpc_pkg::REG_TIMEOUT, 3);
      csr_write(irpc_pkg::REG_LIMIT, 2);
      foreach (directed_ticks[i]) send_word(directed_ticks[i][1], directed_ticks[i][0]);
      settle();

      for (int ph = 0; ph < 4; ph++) begin
         tmo_cur = $urandom_range(2, 12);
         lim_cur = $urandom_range(1, 6);
         csr_write(irpc_pkg::REG_TIMEOUT, tmo_cur);
         csr_write(irpc_pkg::REG_LIMIT, lim_cur);
         req_idle_pct  = idle_pct[ph];
         rsp_stall_pct = stall_pct[ph];
         phase_start   = ticks_sent;
         if (ph == 0) hold_asks++;
         while (ticks_sent - phase_start < 50) begin
            pick = $urandom_range(9);
            if (pick < 6) begin
               capture_train($urandom_range(1, lim_cur + 1), $urandom_range(1, tmo_cur));
               if ($urandom_range(3) != 0) replay_run();
            end else if (pick < 8) noise($urandom_range(3, 12));
            else replay_run();
         end
         settle();
      end

      // register extremes: zero timeout and limit, top timeout, clamped limit
      req_idle_pct  = 20;
      rsp_stall_pct = 20;
      csr_write(irpc_pkg::REG_TIMEOUT, 0);
      csr_write(irpc_pkg::REG_LIMIT, 0);
      capture_train(3, 2);
      noise(12);
      replay_run();
      csr_write(irpc_pkg::REG_TIMEOUT, 5);
      capture_train(3, 4);
      replay_run();
      csr_write(irpc_pkg::REG_TIMEOUT, 1);
      noise(8);
      csr_write(irpc_pkg::REG_TIMEOUT, (1 << irpc_pkg::TIMEOUT_W) - 1);
      csr_write(irpc_pkg::REG_LIMIT, (1 << irpc_pkg::LIMIT_W) - 1);
      csr_write(irpc_pkg::REG_TIMEOUT, 6);
      capture_train(4, 3);
      replay_run();
      csr_write(irpc_pkg::REG_LIMIT, PAIR_SLOTS);
      capture_train(3, 3);
      replay_run();

      wait_quiet();
      repeat (5) @(posedge clock);
      sb.close();
      $display("%0d ticks, %0d words checked: %0d captures done, %0d failed, %0d replays",
               ticks_sent, sb.results_seen, sb.captures_done, sb.captures_failed, sb.replays);
      $display("largest stored train %0d pairs, %0d mismatches", sb.most_pairs, sb.errors);
      if (sb.errors == 0) $display("tb_ir_pulse_capture_replay: clean");
      else $display("tb_ir_pulse_capture_replay: errors");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/irpc_pkg.sv
rtl/core/irpc_pair_mem.sv
rtl/core/irpc_seq.sv
rtl/core/ir_pulse_capture_replay.sv
sim/tb_ir_pulse_capture_replay.sv
